[rtl/nms_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package nms_pkg;

    localparam int FIELD_LANES = 4;
    localparam int DATA_W      = 16;
    localparam int USED_W      = 3;
    localparam int OUT_BITS    = 12;
    localparam int ACC_W       = 32;
    localparam int EXP_W       = 32;
    localparam int TAB_IDX_W   = 5;

    localparam int S_PAYLOAD_W = 2 * FIELD_LANES * DATA_W + USED_W;
    localparam int S_TDATA_W   = ((S_PAYLOAD_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

    // status of the sigmoid unit as seen by the top level
    typedef struct packed {
        logic busy;
        logic res_valid;
    } sig_status_t;

    // round(exp(-2^p) * 2^31), p = -15 .. 4, indexed by p + 15
    function automatic logic [EXP_W-1:0] exp_tab(input logic [TAB_IDX_W-1:0] idx);
        logic [EXP_W-1:0] val;
        case (idx)
            5'd0:    val = 32'd2147418113;
            5'd1:    val = 32'd2147352580;
            5'd2:    val = 32'd2147221520;
            5'd3:    val = 32'd2146959424;
            5'd4:    val = 32'd2146435328;
            5'd5:    val = 32'd2145387520;
            5'd6:    val = 32'd2143293437;
            5'd7:    val = 32'd2139111403;
            5'd8:    val = 32'd2130771798;
            5'd9:    val = 32'd2114190000;
            5'd10:   val = 32'd2081412522;
            5'd11:   val = 32'd2017374191;
            5'd12:   val = 32'd1895147668;
            5'd13:   val = 32'd1672461947;
            5'd14:   val = 32'd1302514674;
            5'd15:   val = 32'd790015084;
            5'd16:   val = 32'd290630308;
            5'd17:   val = 32'd39332535;
            5'd18:   val = 32'd720401;
            5'd19:   val = 32'd242;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

[rtl/nms_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module nms_lane
    import nms_pkg::*;
#(
    parameter int LANE_IDX = 0
) (
    input  wire                     aclk,
    input  wire                     load,
    input  wire signed [DATA_W-1:0] weight,
    input  wire signed [DATA_W-1:0] activ,
    input  wire        [USED_W-1:0] lanes_used,
    output logic signed [ACC_W-1:0] prod
);

    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] prod_next;
    logic                    lane_on;

    assign lane_on = 32'(lanes_used) > 32'(LANE_IDX);

    always_comb begin
        prod_next = '0;
        if (lane_on) begin
            prod_next = ACC_W'(weight * activ);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

[rtl/nms_merge.sv]
`timescale 1ns / 1ps
`default_nettype none

module nms_merge
    import nms_pkg::*;
#(
    parameter int NUM_LANES = 4,
    parameter int FRAC_BITS = 12
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     add_en,
    input  wire                     clear,
    input  wire signed [ACC_W-1:0]  prod [NUM_LANES],
    output logic signed [ACC_W-1:0] acc
);

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] lane_sum;

    always_comb begin
        lane_sum = acc_reg;
        for (int i = 0; i < NUM_LANES; i++) begin
            lane_sum = lane_sum + (prod[i] >>> FRAC_BITS);
        end
    end

    always_comb begin
        acc_next = acc_reg;
        if (clear) begin
            acc_next = '0;
        end else if (add_en) begin
            acc_next = lane_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

[rtl/nms_sigmoid.sv]
`timescale 1ns / 1ps
`default_nettype none

module nms_sigmoid
    import nms_pkg::*;
#(
    parameter int FRAC_BITS = 12
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     start,
    input  wire signed [ACC_W-1:0]  acc,
    input  wire                     res_ready,
    output sig_status_t             status,
    output logic [OUT_BITS-1:0]     result
);

    localparam int MBITS = FRAC_BITS + 5;
    localparam int JW    = $clog2(MBITS);
    localparam int KW    = $clog2(OUT_BITS);
    localparam int TAB_OFS = 15 - FRAC_BITS;
    localparam logic signed [ACC_W-1:0] LIM = ACC_W'(16) << FRAC_BITS;
    localparam logic [EXP_W-1:0] EXP_ONE = EXP_W'(64'd1 << 31);
    localparam logic [2*EXP_W-1:0] RND_HALF = (2*EXP_W)'(64'd1 << 30);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_RND  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } sig_state_t;

    sig_state_t state_reg, state_next;

    logic [MBITS-1:0]      mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic [EXP_W-1:0]      e_reg, e_next;
    logic [2*EXP_W-1:0]    prod_reg, prod_next;
    logic [JW-1:0]         j_reg, j_next;
    logic [KW-1:0]         k_reg, k_next;
    logic [EXP_W:0]        rem_reg, rem_next;
    logic [EXP_W:0]        den_reg, den_next;
    logic [OUT_BITS-1:0]   q_reg, q_next;

    logic [ACC_W-1:0]      mag_full;
    logic [EXP_W-1:0]      e_round;
    logic [EXP_W-1:0]      e_fin;
    logic [EXP_W+1:0]      rem_sh;
    logic [TAB_IDX_W-1:0]  tab_idx;

    always_comb begin
        if (acc > LIM || acc < -LIM) begin
            mag_full = LIM;
        end else if (acc < 0) begin
            mag_full = -acc;
        end else begin
            mag_full = acc;
        end
    end

    assign tab_idx = TAB_IDX_W'(32'(j_reg) + TAB_OFS);
    assign e_round = EXP_W'((prod_reg + RND_HALF) >> 31);
    assign e_fin   = mag_reg[j_reg] ? e_round : e_reg;
    assign rem_sh  = {rem_reg, 1'b0};

    always_comb begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        e_next     = e_reg;
        prod_next  = prod_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        q_next     = q_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    mag_next   = mag_full[MBITS-1:0];
                    neg_next   = acc < 0;
                    e_next     = EXP_ONE;
                    j_next     = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                prod_next  = e_reg * exp_tab(tab_idx);
                state_next = S_RND;
            end
            S_RND: begin
                e_next = e_fin;
                if (32'(j_reg) == MBITS - 1) begin
                    den_next   = {1'b0, EXP_ONE} + {1'b0, e_fin};
                    rem_next   = neg_reg ? {1'b0, e_fin} : {1'b0, EXP_ONE};
                    k_next     = '0;
                    state_next = S_DIV;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_DIV: begin
                if (rem_sh >= {1'b0, den_reg}) begin
                    rem_next = (EXP_W+1)'(rem_sh - {1'b0, den_reg});
                    q_next   = {q_reg[OUT_BITS-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh[EXP_W:0];
                    q_next   = {q_reg[OUT_BITS-2:0], 1'b0};
                end
                k_next = k_reg + 1'b1;
                if (32'(k_reg) == OUT_BITS - 1) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        e_reg    <= e_next;
        prod_reg <= prod_next;
        j_reg    <= j_next;
        k_reg    <= k_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        q_reg    <= q_next;
    end

    assign status.busy      = state_reg != S_IDLE;
    assign status.res_valid = state_reg == S_DONE;
    assign result           = q_reg;

endmodule

`default_nettype wire

[rtl/neuron_mac_sigmoid_q12.sv]
`timescale 1ns / 1ps
`default_nettype none

// Neuron dot product with sigmoid activation, Q4.12 in, Q0.12 out.
// Slave channel (s_): one request carries four weight/activation pairs and a
// count of leading valid lanes; s_tlast marks the last request of a neuron.
// Each lane multiplies in parallel, a merge stage adds the shifted products
// into a 32-bit wrapping accumulator.
// Master channel (m_): one result per neuron, floor(4096*sigmoid(acc)), with
// acc clamped to +-16.0.
// Throughput: non-final requests are taken every cycle. After a final request
// the block stalls its input until the sigmoid unit has handed its result to
// the output register: one shared 32x32 multiplier runs a multiply and a
// round step per magnitude bit for the exponential, then a radix-2 divider
// yields one result bit per cycle.
// The result sits in an output register; a stalled receiver does not block the
// next neuron's accumulation, but that result then waits and stalls the input.
// Reset (aresetn low, synchronous) clears the accumulator and drops m_tvalid.

module neuron_mac_sigmoid_q12
    import nms_pkg::*;
#(
    parameter int LANES     = 4,
    parameter int FRAC_BITS = 12
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    // weight_a, weight_b, weight_c, weight_d, activ_a, activ_b, activ_c,
    // activ_d, lanes_used, zero pad
    input  wire [S_TDATA_W-1:0]  s_tdata,
    input  wire                  s_tlast,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    // activation, zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int NL = (LANES < FIELD_LANES) ? LANES : FIELD_LANES;

    logic                    s_acc;
    logic [USED_W-1:0]       lanes_used;
    logic signed [ACC_W-1:0] prod [NL];
    logic signed [ACC_W-1:0] acc;
    sig_status_t             sig_st;
    logic [OUT_BITS-1:0]     sig_res;
    logic                    res_ready;

    logic                    lane_vld_reg, lane_vld_next;
    logic                    lane_end_reg, lane_end_next;
    logic                    start_reg, start_next;
    logic                    out_vld_reg, out_vld_next;
    logic [OUT_BITS-1:0]     out_data_reg;

    assign s_tready   = !sig_st.busy && !start_reg && !(lane_vld_reg && lane_end_reg);
    assign s_acc      = s_tvalid && s_tready;
    assign lanes_used = s_tdata[2*FIELD_LANES*DATA_W +: USED_W];

    for (genvar i = 0; i < NL; i++) begin : g_lane
        nms_lane #(
            .LANE_IDX (i)
        ) u_lane (
            .aclk       (aclk),
            .load       (s_acc),
            .weight     (s_tdata[i*DATA_W +: DATA_W]),
            .activ      (s_tdata[(FIELD_LANES+i)*DATA_W +: DATA_W]),
            .lanes_used (lanes_used),
            .prod       (prod[i])
        );
    end

    nms_merge #(
        .NUM_LANES (NL),
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .add_en  (lane_vld_reg),
        .clear   (start_reg),
        .prod    (prod),
        .acc     (acc)
    );

    nms_sigmoid #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sigmoid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start_reg),
        .acc       (acc),
        .res_ready (res_ready),
        .status    (sig_st),
        .result    (sig_res)
    );

    assign res_ready = !out_vld_reg || m_tready;

    always_comb begin
        lane_vld_next = s_acc;
        lane_end_next = s_acc ? s_tlast : lane_end_reg;
        start_next    = lane_vld_reg && lane_end_reg;
        out_vld_next  = out_vld_reg;
        if (sig_st.res_valid && res_ready) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_vld_reg <= 1'b0;
            lane_end_reg <= 1'b0;
            start_reg    <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            lane_vld_reg <= lane_vld_next;
            lane_end_reg <= lane_end_next;
            start_reg    <= start_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (sig_st.res_valid && res_ready) begin
            out_data_reg <= sig_res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = M_TDATA_W'(out_data_reg);

endmodule

`default_nettype wire

[rtl/nms_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module nms_checker
    import nms_pkg::*;
(
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 s_tvalid,
    input wire                 s_tready,
    input wire [S_TDATA_W-1:0] s_tdata,
    input wire                 s_tlast,
    input wire                 m_tvalid,
    input wire                 m_tready,
    input wire [M_TDATA_W-1:0] m_tdata
);

    // result held while the receiver stalls
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped under stall");

    // the last request of a neuron blocks the input while the sigmoid runs
    a_last_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken right after end of neuron");

    // no result rises straight after an accepted request
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result too soon after a request");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:OUT_BITS] == '0)
        else $error("pad bits of result not zero");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind neuron_mac_sigmoid_q12 nms_checker u_nms_checker (.*);

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import nms_pkg::*;

    localparam int FRAC      = 12;
    localparam int CLAMP_LIM = 16 << FRAC;
    localparam int TAIL_LEN  = 200;
    localparam int HOLD_CYC  = 400;

    // round(exp(-2^p) * 2^31), p = -15 .. 4
    localparam logic [31:0] NEG_EXP_POW2 [20] = '{
        32'd2147418113, 32'd2147352580, 32'd2147221520, 32'd2146959424,
        32'd2146435328, 32'd2145387520, 32'd2143293437, 32'd2139111403,
        32'd2130771798, 32'd2114190000, 32'd2081412522, 32'd2017374191,
        32'd1895147668, 32'd1672461947, 32'd1302514674, 32'd790015084,
        32'd290630308,  32'd39332535,   32'd720401,     32'd242
    };

    typedef struct {
        logic [S_TDATA_W-1:0] data;
        logic                 last;
    } pack_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    wire                  s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    wire                  m_tvalid;
    logic                 m_tready = 1'b0;
    wire  [M_TDATA_W-1:0] m_tdata;

    pack_t               pack_queue [$];
    logic [OUT_BITS-1:0] act_expect [$];
    logic [31:0]         mac_acc   = '0;
    pack_t               cur_pack;
    int                  send_gap  = 0;
    int                  recv_gap  = 0;
    logic                tail_q    = 1'b0;
    logic                hold_off  = 1'b0;
    int                  pack_cnt  = 0;
    int                  neuron_cnt = 0;
    int                  result_cnt = 0;
    int                  err_cnt   = 0;
    logic [M_TDATA_W-1:0] want_word;

    neuron_mac_sigmoid_q12 dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic logic signed [31:0] lane_dot(input logic [S_TDATA_W-1:0] d);
        logic signed [31:0] sum;
        logic signed [15:0] w;
        logic signed [15:0] a;
        logic signed [31:0] p;
        logic [2:0]         used;
        sum  = '0;
        used = d[130:128];
        for (int i = 0; i < FIELD_LANES; i++) begin
            if (i < used) begin
                w   = d[16*i +: 16];
                a   = d[64 + 16*i +: 16];
                p   = w * a;
                sum = sum + (p >>> FRAC);
            end
        end
        return sum;
    endfunction

    function automatic logic [OUT_BITS-1:0] sigmoid_q12_of(input logic signed [31:0] acc);
        logic signed [31:0] x;
        logic [31:0]        mag;
        logic [63:0]        e;
        logic [63:0]        q;
        x = acc;
        if (x > CLAMP_LIM) x = CLAMP_LIM;
        if (x < -CLAMP_LIM) x = -CLAMP_LIM;
        mag = (x < 0) ? -x : x;
        e = 64'd1 << 31;
        for (int j = 0; j <= FRAC + 4; j++) begin
            if (mag[j]) e = (e * NEG_EXP_POW2[j + 15 - FRAC] + (64'd1 << 30)) >> 31;
        end
        if (x >= 0) q = (64'd1 << (OUT_BITS + 31)) / ((64'd1 << 31) + e);
        else q = (e << OUT_BITS) / ((64'd1 << 31) + e);
        return q[OUT_BITS-1:0];
    endfunction

    function automatic logic [15:0] rand_val(input int mode);
        case (mode)
            0:       return 16'($urandom_range(0, 65535));
            1:       return 16'($urandom_range(0, 16383) - 8192);
            default: return 16'($urandom_range(0, 511) - 256);
        endcase
    endfunction

    function automatic logic [63:0] rand_lanes(input int mode);
        logic [63:0] v;
        for (int i = 0; i < 4; i++) v[16*i +: 16] = rand_val(mode);
        return v;
    endfunction

    task automatic add_pack(input logic [63:0] wts, input logic [63:0] acts,
                            input logic [2:0] used, input logic last);
        pack_t p;
        p.data           = '0;
        p.data[63:0]     = wts;
        p.data[127:64]   = acts;
        p.data[130:128]  = used;
        p.last           = last;
        pack_queue.push_back(p);
    endtask

    task automatic note_fail(input string what, input logic [M_TDATA_W-1:0] want,
                             input logic [M_TDATA_W-1:0] got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("mismatch (%s) at %0t: expected %0d, got %0d", what, $time, want, got);
    endtask

    // stimulus
    initial begin
        int gen_cnt;
        int len;
        int mode;
        int r;
        logic [2:0] used;

        // extremes and lane-count corners
        add_pack({4{16'h7fff}}, {4{16'h7fff}}, 3'd4, 1'b1);
        add_pack({4{16'h8000}}, {4{16'h8000}}, 3'd4, 1'b1);
        add_pack({4{16'h7fff}}, {4{16'h8000}}, 3'd4, 1'b1);
        add_pack({4{16'h7fff}}, {4{16'h7fff}}, 3'd0, 1'b1);
        add_pack({4{16'h0800}}, {4{16'hf800}}, 3'd7, 1'b1);
        add_pack({4{16'h1000}}, {4{16'h1000}}, 3'd5, 1'b0);
        add_pack({4{16'h1000}}, {4{16'hf000}}, 3'd6, 1'b0);
        add_pack({16'h7fff, 16'h7fff, 16'h0400, 16'h0400},
                 {16'h7fff, 16'h7fff, 16'h0400, 16'h0400}, 3'd2, 1'b1);
        // clamp boundary at +-16.0
        add_pack({48'h0, 16'h4000}, {48'h0, 16'h4000}, 3'd1, 1'b1);
        add_pack({48'h0, 16'h4000}, {48'h0, 16'h4000}, 3'd1, 1'b0);
        add_pack({48'h0, 16'h0001}, {48'h0, 16'h1000}, 3'd1, 1'b1);
        add_pack({48'h0, 16'hc000}, {48'h0, 16'h4000}, 3'd1, 1'b1);
        add_pack({48'h0, 16'hc000}, {48'h0, 16'h4000}, 3'd1, 1'b0);
        add_pack({48'h0, 16'hffff}, {48'h0, 16'h1000}, 3'd1, 1'b1);
        // floor of negative products, zero and unit sums
        add_pack({48'h0, 16'hffff}, {48'h0, 16'h0001}, 3'd1, 1'b1);
        add_pack({48'h0, 16'h0001}, {48'h0, 16'h0001}, 3'd1, 1'b1);
        add_pack({48'h0, 16'h1000}, {48'h0, 16'h1000}, 3'd1, 1'b1);
        add_pack({48'h0, 16'hf000}, {48'h0, 16'h1000}, 3'd3, 1'b1);
        add_pack(rand_lanes(1), rand_lanes(1), 3'd4, 1'b0);
        add_pack(rand_lanes(1), rand_lanes(1), 3'd3, 1'b0);
        add_pack(rand_lanes(1), rand_lanes(1), 3'd2, 1'b1);

        gen_cnt = 0;
        while (gen_cnt < 1080) begin
            r = $urandom_range(0, 9);
            if (r < 7) len = $urandom_range(1, 6);
            else if (r < 9) len = $urandom_range(7, 20);
            else len = 1;
            mode = $urandom_range(0, 2);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 6) == 0) used = 3'($urandom_range(0, 7));
                else used = 3'($urandom_range(1, 4));
                add_pack(rand_lanes(mode), rand_lanes(mode), used, k == len - 1);
            end
            gen_cnt += len;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                mac_acc = mac_acc + lane_dot(s_tdata);
                pack_cnt++;
                if (s_tlast) begin
                    act_expect.push_back(sigmoid_q12_of(mac_acc));
                    mac_acc = '0;
                    neuron_cnt++;
                end
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pack_queue.size() != 0) begin
                    cur_pack = pack_queue.pop_front();
                    s_tdata  <= cur_pack.data;
                    s_tlast  <= cur_pack.last;
                    s_tvalid <= 1'b1;
                    if (!tail_q && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 4);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            tail_q <= (pack_queue.size() < TAIL_LEN);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (act_expect.size() == 0) begin
                    note_fail("unexpected result", '0, m_tdata);
                end else begin
                    want_word = '0;
                    want_word[OUT_BITS-1:0] = act_expect.pop_front();
                    result_cnt++;
                    if (m_tdata !== want_word) note_fail("activation", want_word, m_tdata);
                end
            end
            if (recv_gap != 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else if (hold_off) begin
                m_tready <= 1'b0;
            end else if (!tail_q && $urandom_range(0, 5) == 0) begin
                recv_gap <= $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // long receiver hold-off so the output register fills and input backs up
    initial begin
        while (pack_cnt < 600) @(negedge aclk);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYC) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        @(posedge aresetn);
        while (pack_queue.size() != 0 || s_tvalid) @(negedge aclk);
        while (act_expect.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (act_expect.size() != 0) begin
            err_cnt += act_expect.size();
            $display("%0d results never arrived", act_expect.size());
        end
        $display("sent %0d packs over %0d neurons, checked %0d activations, %0d errors",
                 pack_cnt, neuron_cnt, result_cnt, err_cnt);
        $display("lane counts 0..7, +-16.0 clamp, floor of negative products, long output hold-off");
        if (err_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
